// ===== hw/rtl/rom_page_cache_fifo_unit_macros.svh =====
// assertion macros for the rom page cache
`ifndef ROM_PAGE_CACHE_FIFO_UNIT_MACROS_SVH
`define ROM_PAGE_CACHE_FIFO_UNIT_MACROS_SVH

// condition must never hold
`define RPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// consequent holds in the same cycle
`define RPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the next cycle
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rpc_pkg.sv =====
package rpc_pkg;

	localparam int PAGE_BYTES_DEF = 4096;
	localparam int NUM_SLOTS_DEF  = 64;
	localparam int NUM_PAGES_DEF  = 8192;

	localparam int POS_W    = 25;
	localparam int SECTOR_W = 32;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_SET    = 1'b1
	} op_t;

endpackage

// ===== hw/rtl/rpc_in_if.sv =====
interface rpc_in_if;
	logic                            valid;
	logic                            ready;
	rpc_pkg::op_t                    op;
	logic [rpc_pkg::POS_W-1:0]       position;
	logic [rpc_pkg::SECTOR_W-1:0]    sector;

	modport source (output valid, op, position, sector, input ready);
	modport sink   (input valid, op, position, sector, output ready);
endinterface

// ===== hw/rtl/rpc_out_if.sv =====
interface rpc_out_if #(
	parameter int SLOT_W = $clog2(rpc_pkg::NUM_SLOTS_DEF),
	parameter int OFFS_W = $clog2(rpc_pkg::PAGE_BYTES_DEF),
	parameter int PAGE_W = $clog2(rpc_pkg::NUM_PAGES_DEF)
);
	logic                            valid;
	logic                            ready;
	logic                            hit;
	logic [SLOT_W-1:0]               slot;
	logic [OFFS_W-1:0]               offset;
	logic [rpc_pkg::SECTOR_W-1:0]    fetch_sector;
	logic                            evicted_valid;
	logic [PAGE_W-1:0]               evicted_page;

	modport source (output valid, hit, slot, offset, fetch_sector, evicted_valid,
		evicted_page, input ready);
	modport sink   (input valid, hit, slot, offset, fetch_sector, evicted_valid,
		evicted_page, output ready);
endinterface

// ===== hw/rtl/rom_page_cache_fifo_unit.sv =====
// ROM page cache: maps a byte position to a buffer slot and replaces slots in
// FIFO order. A new word is taken only once the last is done: the accept edge
// reads the residency, sector and slot-owner memories, the next edge commits
// the read-modify-write and loads the output register; a stalled output holds
// the item longer. After reset the residency memory is swept clear, one entry
// a cycle, over all NUM_PAGES entries (8192 by default) with req.ready low.
// PAGE_BYTES and NUM_PAGES must be powers of two (not checked by the block).
// A set word writes the page's storage sector and answers all zeros; a miss
// on a page whose sector was never set returns an undefined fetch_sector.
`include "rom_page_cache_fifo_unit_macros.svh"

module rom_page_cache_fifo_unit #(
	parameter int PAGE_BYTES = rpc_pkg::PAGE_BYTES_DEF,
	parameter int NUM_SLOTS  = rpc_pkg::NUM_SLOTS_DEF,
	parameter int NUM_PAGES  = rpc_pkg::NUM_PAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rpc_in_if.sink     req,
	rpc_out_if.source  rsp
);

	localparam int OFFS_W = $clog2(PAGE_BYTES);
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int PAGE_W = $clog2(NUM_PAGES);

	logic                         acc;
	logic [PAGE_W-1:0]            page_in;
	logic                         init_done;

	logic                         busy_s1;
	rpc_pkg::op_t                 op_s1;
	logic [PAGE_W-1:0]            page_s1;
	logic [OFFS_W-1:0]            offs_s1;
	logic                         fwd_clr_s1;

	logic                         res_valid;
	logic [SLOT_W-1:0]            res_slot;
	logic [rpc_pkg::SECTOR_W-1:0] sector_rd;
	logic [SLOT_W-1:0]            victim;
	logic                         victim_used;
	logic [PAGE_W-1:0]            victim_owner;

	logic                         hit_now;
	logic                         miss_now;
	logic                         out_free;
	logic                         done;

	logic                         clr_pend_q;
	logic [PAGE_W-1:0]            clr_page_q;
	logic                         out_valid_q;

	assign page_in = PAGE_W'(req.position >> OFFS_W);
	assign acc     = req.valid && req.ready;

	assign req.ready = init_done && !busy_s1;

	// a clear landing on the same edge as the read is not seen by the memory
	assign hit_now  = (op_s1 == rpc_pkg::OP_LOOKUP) && res_valid && !fwd_clr_s1;
	assign miss_now = (op_s1 == rpc_pkg::OP_LOOKUP) && !(res_valid && !fwd_clr_s1);
	assign out_free = !out_valid_q || rsp.ready;
	assign done     = busy_s1 && out_free;

	rpc_res_table #(
		.NUM_PAGES (NUM_PAGES),
		.SLOT_W    (SLOT_W)
	) u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_page   (page_in),
		.rd_valid  (res_valid),
		.rd_slot   (res_slot),
		.set_en    (done && miss_now),
		.set_page  (page_s1),
		.set_slot  (victim),
		.clr_en    (clr_pend_q),
		.clr_page  (clr_page_q),
		.init_done (init_done)
	);

	rpc_sector_table #(
		.NUM_PAGES (NUM_PAGES)
	) u_sector (
		.clk       (clk),
		.we        (acc && (req.op == rpc_pkg::OP_SET)),
		.wr_page   (page_in),
		.wr_sector (req.sector),
		.rd_en     (acc),
		.rd_page   (page_in),
		.rd_sector (sector_rd)
	);

	rpc_slot_table #(
		.NUM_SLOTS (NUM_SLOTS),
		.PAGE_W    (PAGE_W)
	) u_slot (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (acc),
		.fill_en      (done && miss_now),
		.fill_page    (page_s1),
		.victim       (victim),
		.victim_used  (victim_used),
		.victim_owner (victim_owner)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			clr_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			clr_pend_q <= done && miss_now && victim_used;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1      <= req.op;
			page_s1    <= page_in;
			offs_s1    <= OFFS_W'(req.position);
			fwd_clr_s1 <= clr_pend_q && (clr_page_q == page_in);
		end
		if (done) begin
			clr_page_q        <= victim_owner;
			rsp.hit           <= hit_now;
			rsp.slot          <= hit_now ? res_slot : (miss_now ? victim : '0);
			rsp.offset        <= (op_s1 == rpc_pkg::OP_LOOKUP) ? offs_s1 : '0;
			rsp.fetch_sector  <= miss_now ? sector_rd : '0;
			rsp.evicted_valid <= miss_now && victim_used;
			rsp.evicted_page  <= (miss_now && victim_used) ? victim_owner : '0;
		end
	end

	assign rsp.valid = out_valid_q;

	`RPC_ASSERT_NEVER(a_res_write_clash, clk, arst_n, done && miss_now && clr_pend_q, "residency set and eviction clear on one edge")
	`RPC_ASSERT_SAME(a_evict_not_self, clk, arst_n, done && miss_now && victim_used, victim_owner != page_s1, "miss evicts its own page")
	`RPC_ASSERT_NEXT(a_victim_advance, clk, arst_n, done && miss_now, victim != $past(victim), "fifo pointer did not move on a miss")
	`RPC_ASSERT_SAME(a_no_accept_in_sweep, clk, arst_n, req.valid && req.ready, init_done && !clr_pend_q || init_done, "word taken during residency sweep")

endmodule

// ===== hw/rtl/rpc_res_table.sv =====
module rpc_res_table #(
	parameter int NUM_PAGES = rpc_pkg::NUM_PAGES_DEF,
	parameter int SLOT_W    = $clog2(rpc_pkg::NUM_SLOTS_DEF),
	localparam int PAGE_W   = $clog2(NUM_PAGES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [PAGE_W-1:0] rd_page,
	output logic              rd_valid,
	output logic [SLOT_W-1:0] rd_slot,
	input  logic              set_en,
	input  logic [PAGE_W-1:0] set_page,
	input  logic [SLOT_W-1:0] set_slot,
	input  logic              clr_en,
	input  logic [PAGE_W-1:0] clr_page,
	output logic              init_done
);

	logic [SLOT_W:0]   mem [NUM_PAGES];
	logic [SLOT_W:0]   rd_q;
	logic [PAGE_W-1:0] sweep_q;
	logic              sweep_active_q;
	logic              we;
	logic [PAGE_W-1:0] wa;
	logic [SLOT_W:0]   wd;

	// clearing sweep after reset, then resident set and eviction clear
	always_comb begin
		priority if (sweep_active_q) begin
			we = 1'b1;
			wa = sweep_q;
			wd = '0;
		end else if (set_en) begin
			we = 1'b1;
			wa = set_page;
			wd = {1'b1, set_slot};
		end else if (clr_en) begin
			we = 1'b1;
			wa = clr_page;
			wd = '0;
		end else begin
			we = 1'b0;
			wa = set_page;
			wd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q        <= '0;
			sweep_active_q <= 1'b1;
		end else if (sweep_active_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == PAGE_W'(NUM_PAGES - 1)) begin
				sweep_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_page];
		end
	end

	assign rd_valid  = rd_q[SLOT_W];
	assign rd_slot   = rd_q[SLOT_W-1:0];
	assign init_done = !sweep_active_q;

endmodule

// ===== hw/rtl/rpc_sector_table.sv =====
module rpc_sector_table #(
	parameter int NUM_PAGES = rpc_pkg::NUM_PAGES_DEF,
	localparam int PAGE_W   = $clog2(NUM_PAGES)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [PAGE_W-1:0]            wr_page,
	input  logic [rpc_pkg::SECTOR_W-1:0] wr_sector,
	input  logic                         rd_en,
	input  logic [PAGE_W-1:0]            rd_page,
	output logic [rpc_pkg::SECTOR_W-1:0] rd_sector
);

	logic [rpc_pkg::SECTOR_W-1:0] mem [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_page] <= wr_sector;
		end
		if (rd_en) begin
			rd_sector <= mem[rd_page];
		end
	end

endmodule

// ===== hw/rtl/rpc_slot_table.sv =====
module rpc_slot_table #(
	parameter int NUM_SLOTS = rpc_pkg::NUM_SLOTS_DEF,
	parameter int PAGE_W    = $clog2(rpc_pkg::NUM_PAGES_DEF),
	localparam int SLOT_W   = $clog2(NUM_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic              fill_en,
	input  logic [PAGE_W-1:0] fill_page,
	output logic [SLOT_W-1:0] victim,
	output logic              victim_used,
	output logic [PAGE_W-1:0] victim_owner
);

	logic [PAGE_W-1:0]    mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] used_q;
	logic [SLOT_W-1:0]    victim_q;
	logic                 used_rd_q;
	logic [PAGE_W-1:0]    owner_rd_q;

	// fifo pointer and per-slot used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			victim_q  <= '0;
			used_rd_q <= 1'b0;
		end else begin
			if (rd_en) begin
				used_rd_q <= used_q[victim_q];
			end
			if (fill_en) begin
				used_q[victim_q] <= 1'b1;
				victim_q <= (victim_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : victim_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_en) begin
			mem[victim_q] <= fill_page;
		end
		if (rd_en) begin
			owner_rd_q <= mem[victim_q];
		end
	end

	assign victim       = victim_q;
	assign victim_used  = used_rd_q;
	assign victim_owner = owner_rd_q;

endmodule

// ===== tb/rpc_translation_checker.sv =====
module rpc_translation_checker (
	input  logic clk,
	input  logic arst_n,
	rpc_in_if    req,
	rpc_out_if   rsp,
	output int   faults,
	output int   outstanding,
	output int   hits,
	output int   misses,
	output int   evictions,
	output int   sector_writes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_W = $clog2(rpc_pkg::NUM_SLOTS_DEF);
	localparam int OFFS_W = $clog2(rpc_pkg::PAGE_BYTES_DEF);
	localparam int PAGE_W = $clog2(rpc_pkg::NUM_PAGES_DEF);

	typedef struct packed {
		logic                         hit;
		logic [SLOT_W-1:0]            slot;
		logic [OFFS_W-1:0]            offset;
		logic [rpc_pkg::SECTOR_W-1:0] fetch_sector;
		logic                         evicted_valid;
		logic [PAGE_W-1:0]            evicted_page;
	} xlate_t;

	bit                           resident    [rpc_pkg::NUM_PAGES_DEF];
	logic [SLOT_W-1:0]            home_slot   [rpc_pkg::NUM_PAGES_DEF];
	logic [rpc_pkg::SECTOR_W-1:0] page_sector [rpc_pkg::NUM_PAGES_DEF];
	bit                           slot_taken  [rpc_pkg::NUM_SLOTS_DEF];
	logic [PAGE_W-1:0]            slot_page   [rpc_pkg::NUM_SLOTS_DEF];
	logic [SLOT_W-1:0]            fifo_ptr;
	xlate_t                       pending_xlates[$];

	function automatic xlate_t translate(rpc_pkg::op_t op, logic [rpc_pkg::POS_W-1:0] pos,
		logic [rpc_pkg::SECTOR_W-1:0] sec);
		xlate_t            r;
		logic [PAGE_W-1:0] pg;
		r = '0;
		pg = pos[OFFS_W +: PAGE_W];
		if (op == rpc_pkg::OP_SET) begin
			page_sector[pg] = sec;
			sector_writes++;
			return r;
		end
		r.offset = pos[OFFS_W-1:0];
		if (resident[pg]) begin
			r.hit = 1'b1;
			r.slot = home_slot[pg];
			hits++;
		end else begin
			// fifo victim, an empty slot evicts nothing
			if (slot_taken[fifo_ptr]) begin
				resident[slot_page[fifo_ptr]] = 1'b0;
				r.evicted_valid = 1'b1;
				r.evicted_page = slot_page[fifo_ptr];
				evictions++;
			end
			slot_taken[fifo_ptr] = 1'b1;
			slot_page[fifo_ptr] = pg;
			resident[pg] = 1'b1;
			home_slot[pg] = fifo_ptr;
			r.fetch_sector = page_sector[pg];
			r.slot = fifo_ptr;
			fifo_ptr++;
			misses++;
		end
		return r;
	endfunction

	task automatic report_fault(string msg);
		$display("%0t ns: ERROR %s", $time, msg);
		faults++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_fault($sformatf("%s 0x%0h, expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		xlate_t want;
		int     i;
		if (!arst_n) begin
			for (i = 0; i < rpc_pkg::NUM_PAGES_DEF; i++) begin
				resident[i] = 1'b0;
				page_sector[i] = '0;
			end
			for (i = 0; i < rpc_pkg::NUM_SLOTS_DEF; i++)
				slot_taken[i] = 1'b0;
			fifo_ptr = '0;
			pending_xlates.delete();
			faults = 0;
			outstanding = 0;
			hits = 0;
			misses = 0;
			evictions = 0;
			sector_writes = 0;
		end else begin
			// results first: a word accepted at this edge cannot answer yet
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_xlates.size() == 0) begin
					report_fault("result word with nothing pending");
				end else begin
					want = pending_xlates.pop_front();
					check_field("hit", rsp.hit, want.hit);
					check_field("slot", rsp.slot, want.slot);
					check_field("offset", rsp.offset, want.offset);
					check_field("fetch_sector", rsp.fetch_sector, want.fetch_sector);
					check_field("evicted_valid", rsp.evicted_valid, want.evicted_valid);
					check_field("evicted_page", rsp.evicted_page, want.evicted_page);
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				pending_xlates.push_back(translate(req.op, req.position, req.sector));
			outstanding = pending_xlates.size();
		end
	end

endmodule

// ===== tb/tb_rom_page_cache_fifo_unit.sv =====
module tb_rom_page_cache_fifo_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 200;

	logic clk;
	logic arst_n;
	bit   calm;
	bit   sink_hold;
	int   faults;
	int   outstanding;
	int   hits;
	int   misses;
	int   evictions;
	int   sector_writes;
	int   words_sent;
	bit   sector_known [rpc_pkg::NUM_PAGES_DEF];
	int   pool [256];
	int   pool_sizes [PHASES] = '{40, 90, 16, 130, 66, 250, 64};

	rpc_in_if  req_if ();
	rpc_out_if rsp_if ();

	rom_page_cache_fifo_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	rpc_translation_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_if),
		.rsp           (rsp_if),
		.faults        (faults),
		.outstanding   (outstanding),
		.hits          (hits),
		.misses        (misses),
		.evictions     (evictions),
		.sector_writes (sector_writes)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#16_000_000;
		$display("rom_page_cache_fifo_unit test failed");
		$finish;
	end

	// mostly no gap, sometimes a short one, rarely a long one; never one when calm
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(rpc_pkg::op_t op, logic [12:0] pg, logic [11:0] offs,
		logic [rpc_pkg::SECTOR_W-1:0] sec);
		int n;
		n = gap_cycles();
		if (n > 0) begin
			req_if.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.position <= {pg, offs};
		req_if.sector <= sec;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		if (op == rpc_pkg::OP_SET)
			sector_known[pg] = 1'b1;
		words_sent++;
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// result side
	initial begin
		int n;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				sink_hold = 1'b0;
			end else begin
				n = gap_cycles();
				if (n > 0) begin
					rsp_if.ready <= 1'b0;
					repeat (n) @(negedge clk);
				end
			end
			rsp_if.ready <= 1'b1;
		end
	end

	initial begin
		int          ph;
		int          k;
		logic [12:0] pg;
		arst_n = 1'b0;
		calm = 1'b1;
		sink_hold = 1'b0;
		words_sent = 0;
		req_if.valid = 1'b0;
		req_if.op = rpc_pkg::OP_LOOKUP;
		req_if.position = '0;
		req_if.sector = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, empty-slot misses, hits, patching a resident page
		send_word(rpc_pkg::OP_SET, 13'd0, 12'hFFF, 32'h0000_0000);
		send_word(rpc_pkg::OP_SET, 13'h1FFF, 12'h000, 32'hFFFF_FFFF);
		send_word(rpc_pkg::OP_SET, 13'd1, 12'h800, $urandom());
		send_word(rpc_pkg::OP_LOOKUP, 13'd0, 12'h000, 32'hFFFF_FFFF);
		send_word(rpc_pkg::OP_LOOKUP, 13'h1FFF, 12'hFFF, 32'h0000_0000);
		send_word(rpc_pkg::OP_LOOKUP, 13'd0, 12'hFFF, $urandom());
		send_word(rpc_pkg::OP_SET, 13'd0, 12'h123, 32'h1234_5678);
		send_word(rpc_pkg::OP_LOOKUP, 13'd0, 12'h7FF, 32'h0000_0000);
		send_word(rpc_pkg::OP_LOOKUP, 13'd1, 12'h001, 32'h0000_0000);
		send_word(rpc_pkg::OP_SET, 13'h0AAA, 12'hAAA, 32'hAAAA_AAAA);
		send_word(rpc_pkg::OP_SET, 13'h1555, 12'h555, 32'h5555_5555);
		send_word(rpc_pkg::OP_LOOKUP, 13'h0AAA, 12'h555, 32'h0000_0000);
		send_word(rpc_pkg::OP_LOOKUP, 13'h1555, 12'hAAA, 32'hFFFF_FFFF);
		send_word(rpc_pkg::OP_LOOKUP, 13'h1FFF, 12'h000, 32'h0000_0000);
		drain();

		// random: a page pool per phase, its size sets the hit/eviction mix
		for (ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 0) || ($urandom_range(0, 3) == 0);
			for (k = 0; k < pool_sizes[ph]; k++)
				pool[k] = $urandom_range(0, rpc_pkg::NUM_PAGES_DEF - 1);
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (ph == 2 && k == 50)
					sink_hold = 1'b1;
				if (ph == 4 && k == 100)
					drain();
				pg = 13'(pool[$urandom_range(0, pool_sizes[ph] - 1)]);
				// a page's sector is always set before it is looked up
				if (!sector_known[pg] || $urandom_range(0, 7) == 0)
					send_word(rpc_pkg::OP_SET, pg, 12'($urandom_range(0, 4095)), $urandom());
				else
					send_word(rpc_pkg::OP_LOOKUP, pg, 12'($urandom_range(0, 4095)),
						$urandom());
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("covered %0d words: %0d sector writes, %0d hits, %0d misses, %0d evictions",
			words_sent, sector_writes, hits, misses, evictions);
		$display("with random gaps, a %0d-cycle result stall and a full drain mid-run",
			HOLD_CYCLES);
		if (faults == 0 && outstanding == 0)
			$display("rom_page_cache_fifo_unit test passed");
		else
			$display("rom_page_cache_fifo_unit test failed");
		$finish;
	end

endmodule
